/* hw/rtl/rrq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_pkg: shared types and constants of the random removal queue
// Port widths, parameter defaults, operation and status codes.
// ----------------------------------------------------------------------------
package rrq_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_ITEM_WIDTH = 32;
	localparam int DEF_RAND_WIDTH = 16;

	localparam int OP_W        = 2;
	localparam int ITEM_PORT_W = 32;
	localparam int RAND_PORT_W = 16;
	localparam int STAT_W      = 2;
	localparam int FILL_PORT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUT      = 2'd0,
		OP_PUT_IGN  = 2'd1,
		OP_PUT_MOVE = 2'd2,
		OP_GET      = 2'd3
	} rrq_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_DUP   = 2'd3
	} rrq_status_t;

endpackage

/* hw/rtl/rrq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/rrq_rem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_rem: iterative remainder unit
// Restoring division, one dividend bit per cycle; pulses done with the
// remainder of dividend by divisor.
// ----------------------------------------------------------------------------
module rrq_rem #(
	parameter int DW = 16,
	parameter int VW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [VW-1:0] remainder
);

	localparam int NW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [VW-1:0] div_q;
	logic [VW-1:0] rem_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic [VW-1:0] rem_nxt;
	logic          last;

	assign trial   = {rem_q, dvd_q[DW-1]};
	assign diff    = trial - {1'b0, div_q};
	assign rem_nxt = (trial >= {1'b0, div_q}) ? diff[VW-1:0] : trial[VW-1:0];
	assign last    = (cnt_q == NW'(DW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

/* hw/rtl/random_removal_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_removal_queue: bounded item store with removal at random positions
// Put, put ignoring duplicates, put moving duplicate to end, and get at
// index rand_value mod count; one result beat per input beat.
// ----------------------------------------------------------------------------
// The store holds up to CAPACITY items in a single-port-read RAM and takes
// one operation at a time; in_ready is low while an operation runs. The
// duplicate-checking puts scan the stored items one RAM read per cycle. A
// put that moves a duplicate reads the entries behind it while shifting
// them down. A get runs the remainder unit and then does two RAM reads and
// one write. A get on an empty store answers without running the remainder
// unit; a put that finds the store full takes as long as one that
// succeeds. The result sits in an output register, so a new item is taken
// while the previous result waits for out_ready.
// ----------------------------------------------------------------------------
module random_removal_queue #(
	parameter int CAPACITY   = rrq_pkg::DEF_CAPACITY,
	parameter int ITEM_WIDTH = rrq_pkg::DEF_ITEM_WIDTH,
	parameter int RAND_WIDTH = rrq_pkg::DEF_RAND_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rrq_pkg::OP_W-1:0]        op,
	input  logic [rrq_pkg::ITEM_PORT_W-1:0] item_value,
	input  logic [rrq_pkg::RAND_PORT_W-1:0] rand_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rrq_pkg::ITEM_PORT_W-1:0] item_out,
	output logic [rrq_pkg::STAT_W-1:0]      status,
	output logic [rrq_pkg::FILL_PORT_W-1:0] fill_count
);

	import rrq_pkg::*;

	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int IKW = (ITEM_WIDTH < ITEM_PORT_W) ? ITEM_WIDTH : ITEM_PORT_W;
	localparam int RKW = (RAND_WIDTH < RAND_PORT_W) ? RAND_WIDTH : RAND_PORT_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [AW:0]   CAP_A = (AW + 1)'(CAPACITY);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_SHIFT = 8'b0000_0100,
		S_APP   = 8'b0000_1000,
		S_REM   = 8'b0001_0000,
		S_GRD   = 8'b0010_0000,
		S_GWR   = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t                  state_q, state_d;
	rrq_op_t                 op_q, op_d;
	logic [ITEM_WIDTH-1:0]   item_q, item_d;
	logic [ITEM_WIDTH-1:0]   got_q, got_d;
	logic [CW-1:0]           count_q, count_d;
	logic [CW-1:0]           scan_q, scan_d;
	logic [AW-1:0]           ci_q, ci_d;
	logic                    rv_q, rv_d;
	logic [AW-1:0]           idx_q, idx_d;
	rrq_status_t             st_q, st_d;
	logic                    ov_q, ov_d;
	logic [ITEM_PORT_W-1:0]  oitem_q, oitem_d;
	rrq_status_t             ost_q, ost_d;
	logic [FILL_PORT_W-1:0]  ofill_q, ofill_d;

	logic                    ram_we;
	logic [AW-1:0]           ram_wa;
	logic [ITEM_WIDTH-1:0]   ram_wd;
	logic                    ram_re;
	logic [AW-1:0]           ram_ra;
	logic [ITEM_WIDTH-1:0]   ram_rd;
	logic                    rem_start;
	logic                    rem_done;
	logic [CW-1:0]           rem_val;
	logic                    match;

	assign match = rv_q && (ram_rd == item_q);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		item_d    = item_q;
		got_d     = got_q;
		count_d   = count_q;
		scan_d    = scan_q;
		ci_d      = ci_q;
		rv_d      = rv_q;
		idx_d     = idx_q;
		st_d      = st_q;
		ov_d      = ov_q;
		oitem_d   = oitem_q;
		ost_d     = ost_q;
		ofill_d   = ofill_q;
		ram_we    = 1'b0;
		ram_wa    = '0;
		ram_wd    = item_q;
		ram_re    = 1'b0;
		ram_ra    = '0;
		rem_start = 1'b0;

		if (ov_q && out_ready) begin
			ov_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d   = rrq_op_t'(op);
					item_d = ITEM_WIDTH'(item_value[IKW-1:0]);
					got_d  = '0;
					scan_d = '0;
					rv_d   = 1'b0;
					unique case (rrq_op_t'(op))
						OP_PUT: begin
							state_d = S_APP;
						end
						OP_PUT_IGN, OP_PUT_MOVE: begin
							state_d = S_SCAN;
						end
						OP_GET: begin
							if (count_q == '0) begin
								st_d    = ST_EMPTY;
								state_d = S_FIN;
							end else begin
								rem_start = 1'b1;
								state_d   = S_REM;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (match) begin
					if (op_q == OP_PUT_IGN) begin
						st_d    = ST_DUP;
						state_d = S_FIN;
					end else begin
						scan_d  = CW'(ci_q) + CW'(1);
						rv_d    = 1'b0;
						state_d = S_SHIFT;
					end
				end else if (scan_q < count_q) begin
					ram_re = 1'b1;
					ram_ra = scan_q[AW-1:0];
					ci_d   = scan_q[AW-1:0];
					rv_d   = 1'b1;
					scan_d = scan_q + CW'(1);
				end else begin
					rv_d    = 1'b0;
					state_d = S_APP;
				end
			end
			S_SHIFT: begin
				if (rv_q) begin
					ram_we = 1'b1;
					ram_wa = ci_q - AW'(1);
					ram_wd = ram_rd;
				end
				if (scan_q < count_q) begin
					ram_re = 1'b1;
					ram_ra = scan_q[AW-1:0];
					ci_d   = scan_q[AW-1:0];
					rv_d   = 1'b1;
					scan_d = scan_q + CW'(1);
				end else begin
					rv_d = 1'b0;
					if (!rv_q) begin
						ram_we  = 1'b1;
						ram_wa  = AW'(count_q - CW'(1));
						ram_wd  = item_q;
						st_d    = ST_OK;
						state_d = S_FIN;
					end
				end
			end
			S_APP: begin
				if (count_q == CAP_C) begin
					st_d = ST_FULL;
				end else begin
					ram_we  = 1'b1;
					ram_wa  = count_q[AW-1:0];
					ram_wd  = item_q;
					count_d = count_q + CW'(1);
					st_d    = ST_OK;
				end
				state_d = S_FIN;
			end
			S_REM: begin
				if (rem_done) begin
					idx_d   = rem_val[AW-1:0];
					ram_re  = 1'b1;
					ram_ra  = rem_val[AW-1:0];
					state_d = S_GRD;
				end
			end
			S_GRD: begin
				got_d   = ram_rd;
				ram_re  = 1'b1;
				ram_ra  = AW'(count_q - CW'(1));
				state_d = S_GWR;
			end
			S_GWR: begin
				ram_we  = 1'b1;
				ram_wa  = idx_q;
				ram_wd  = ram_rd;
				count_d = count_q - CW'(1);
				st_d    = ST_OK;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!ov_q || out_ready) begin
					ov_d    = 1'b1;
					oitem_d = ITEM_PORT_W'(got_q[IKW-1:0]);
					ost_d   = st_q;
					ofill_d = FILL_PORT_W'(count_q);
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rv_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rv_q    <= rv_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		item_q  <= item_d;
		got_q   <= got_d;
		scan_q  <= scan_d;
		ci_q    <= ci_d;
		idx_q   <= idx_d;
		st_q    <= st_d;
		oitem_q <= oitem_d;
		ost_q   <= ost_d;
		ofill_q <= ofill_d;
	end

	rrq_ram #(
		.WIDTH (ITEM_WIDTH),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.re    (ram_re),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	rrq_rem #(
		.DW (RKW),
		.VW (CW)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (rand_value[RKW-1:0]),
		.divisor   (count_q),
		.done      (rem_done),
		.remainder (rem_val)
	);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = ov_q;
	assign item_out   = oitem_q;
	assign status     = ost_q;
	assign fill_count = ofill_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("fill count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && st_q == ST_FULL) |-> count_q == CAP_C)
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && st_q == ST_EMPTY) |-> count_q == '0)
		else $error("empty status with items stored");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> {1'b0, ram_wa} < CAP_A)
		else $error("store write beyond capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while busy");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for random_removal_queue
// Mirrors the item store in a class that predicts item_out, status and
// fill_count for every input beat, then checks each output beat against the
// oldest prediction. A directed pass covers the empty and full corners and
// every duplicate rule; a long random pass follows, with random gaps on both
// sides and one extended output hold-off that backs up the input.
// ----------------------------------------------------------------------------

typedef struct {
	logic [rrq_pkg::ITEM_PORT_W-1:0] item;
	rrq_pkg::rrq_status_t            status;
	logic [rrq_pkg::FILL_PORT_W-1:0] fill;
} rrq_reply_t;

class rrq_shadow;
	localparam int DEPTH = rrq_pkg::DEF_CAPACITY;

	logic [rrq_pkg::ITEM_PORT_W-1:0] items [DEPTH];
	int                              count;
	rrq_reply_t                      owed_replies [$];
	int                              mismatches;

	function new();
		count      = 0;
		mismatches = 0;
	endfunction

	function int locate(logic [rrq_pkg::ITEM_PORT_W-1:0] v);
		int i;
		for (i = 0; i < count; i++)
			if (items[i] == v)
				return i;
		return -1;
	endfunction

	function rrq_pkg::rrq_status_t push_item(logic [rrq_pkg::ITEM_PORT_W-1:0] v);
		if (count >= DEPTH)
			return rrq_pkg::ST_FULL;
		items[count] = v;
		count++;
		return rrq_pkg::ST_OK;
	endfunction

	function void note_request(rrq_pkg::rrq_op_t kind, logic [rrq_pkg::ITEM_PORT_W-1:0] v,
	                           logic [rrq_pkg::RAND_PORT_W-1:0] r);
		rrq_reply_t rep;
		int         pos;
		int         idx;
		int         i;
		rep.item   = '0;
		rep.status = rrq_pkg::ST_OK;
		case (kind)
			rrq_pkg::OP_PUT: begin
				rep.status = push_item(v);
			end
			rrq_pkg::OP_PUT_IGN: begin
				if (locate(v) >= 0)
					rep.status = rrq_pkg::ST_DUP;
				else
					rep.status = push_item(v);
			end
			rrq_pkg::OP_PUT_MOVE: begin
				pos = locate(v);
				if (pos >= 0) begin
					count--;
					for (i = pos; i < count; i++)
						items[i] = items[i + 1];
				end
				rep.status = push_item(v);
			end
			default: begin
				if (count == 0) begin
					rep.status = rrq_pkg::ST_EMPTY;
				end else begin
					idx      = int'(r) % count;
					rep.item = items[idx];
					count--;
					items[idx] = items[count];
				end
			end
		endcase
		rep.fill = count[rrq_pkg::FILL_PORT_W-1:0];
		owed_replies.push_back(rep);
	endfunction

	function void report(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
	endfunction

	function void check_response(logic [rrq_pkg::ITEM_PORT_W-1:0] item,
	                             logic [rrq_pkg::STAT_W-1:0] st,
	                             logic [rrq_pkg::FILL_PORT_W-1:0] fill);
		rrq_reply_t want;
		if (owed_replies.size() == 0) begin
			mismatches++;
			$display("%0t ns: unexpected output beat, expected none, actual item %0h status %0d fill %0d",
			         $time, item, st, fill);
			return;
		end
		want = owed_replies.pop_front();
		if (item !== want.item)
			report("item_out", want.item, item);
		if (st !== want.status)
			report("status", want.status, st);
		if (fill !== want.fill)
			report("fill_count", want.fill, fill);
	endfunction
endclass

module tb_top;
	import rrq_pkg::*;

	localparam int RANDOM_BEATS = 750;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [OP_W-1:0]        op;
	logic [ITEM_PORT_W-1:0] item_value;
	logic [RAND_PORT_W-1:0] rand_value;
	logic                   out_valid;
	logic                   out_ready;
	logic [ITEM_PORT_W-1:0] item_out;
	logic [STAT_W-1:0]      status;
	logic [FILL_PORT_W-1:0] fill_count;

	rrq_shadow              shadow;
	logic [ITEM_PORT_W-1:0] recent_items [$];
	bit                     send_burst;
	int                     cycles;

	random_removal_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.item_value (item_value),
		.rand_value (rand_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.item_out   (item_out),
		.status     (status),
		.fill_count (fill_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_beat(rrq_op_t kind, logic [ITEM_PORT_W-1:0] v,
	                         logic [RAND_PORT_W-1:0] r);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= kind;
		item_value <= v;
		rand_value <= r;
		do @(posedge clk); while (!in_ready);
		shadow.note_request(kind, v, r);
		if (kind != OP_GET) begin
			recent_items.push_back(v);
			if (recent_items.size() > 32)
				void'(recent_items.pop_front());
		end
	endtask

	function automatic logic [ITEM_PORT_W-1:0] pick_item();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4)
			return $urandom_range(0, 7);
		if (k < 7 && recent_items.size() > 0)
			return recent_items[$urandom_range(0, recent_items.size() - 1)];
		return $urandom;
	endfunction

	function automatic logic [RAND_PORT_W-1:0] pick_rand();
		int k;
		k = $urandom_range(0, 7);
		if (k == 0)
			return '0;
		if (k == 1)
			return '1;
		return $urandom_range(0, 65535);
	endfunction

	task automatic drain_replies();
		int replies;
		int gap;
		bit burst;
		replies = 0;
		burst   = 1'b0;
		forever begin
			if (replies % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (replies == HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = burst ? 0 : $urandom_range(0, 6);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			shadow.check_response(item_out, status, fill_count);
			replies++;
		end
	endtask

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int      n;
		int      bias;
		int      put_pct;
		int      pick;
		rrq_op_t kind;

		shadow     = new();
		send_burst = 1'b0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		op         <= OP_PUT;
		item_value <= '0;
		rand_value <= '0;
		out_ready  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drain_replies();
		join_none

		// corners: empty get, extremes, duplicate rules, fill to full
		send_beat(OP_GET, $urandom, '1);
		send_beat(OP_PUT, '0, '0);
		send_beat(OP_PUT, '1, '1);
		send_beat(OP_PUT_IGN, '0, $urandom_range(0, 65535));
		send_beat(OP_PUT_MOVE, '1, $urandom_range(0, 65535));
		send_beat(OP_PUT_MOVE, '0, $urandom_range(0, 65535));
		for (n = 0; n < 14; n++) begin
			kind = (n % 3 == 0) ? OP_PUT_IGN : (n % 3 == 1) ? OP_PUT_MOVE : OP_PUT;
			send_beat(kind, 32'h5a5a_0000 + n, $urandom_range(0, 65535));
		end
		send_beat(OP_PUT, 32'h0000_0005, $urandom_range(0, 65535));
		send_beat(OP_PUT_IGN, 32'h0000_0006, $urandom_range(0, 65535));
		send_beat(OP_PUT_IGN, '1, $urandom_range(0, 65535));
		send_beat(OP_PUT_MOVE, '0, $urandom_range(0, 65535));
		send_beat(OP_PUT_MOVE, 32'h0000_0007, $urandom_range(0, 65535));
		send_beat(OP_GET, $urandom, '0);
		send_beat(OP_GET, $urandom, '1);

		bias = 0;
		for (n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 30 == 0) begin
				bias       = $urandom_range(0, 2);
				send_burst = ($urandom_range(0, 3) == 0);
			end
			put_pct = (bias == 0) ? 80 : (bias == 1) ? 25 : 55;
			if ($urandom_range(0, 99) < put_pct) begin
				pick = $urandom_range(0, 2);
				kind = (pick == 0) ? OP_PUT : (pick == 1) ? OP_PUT_IGN : OP_PUT_MOVE;
			end else begin
				kind = OP_GET;
			end
			send_beat(kind, pick_item(), pick_rand());
		end
		in_valid <= 1'b0;

		while (shadow.owed_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (shadow.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
